// File: src/fcd_pkg.sv
// shared constants, types and helpers for the frame change delta encoder
`default_nettype none

package fcd_pkg;

    localparam int FRAME_BYTES = 65536;
    localparam int ADDR_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int MARK_W      = ADDR_W + 1;
    localparam int PIX_W       = 8;
    localparam int POS_W       = 16;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_BYTES - 1);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [PIX_W-1:0]  pix_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        pix_t             value;
        logic             is_change;
        logic             frame_end;
    } result_t;

    // absolute difference of two bytes
    function automatic pix_t abs_diff(input pix_t a, input pix_t b);
        pix_t d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

`default_nettype wire

// File: src/frame_change_delta_encoder_top.sv
// top level of the frame change delta encoder
`default_nettype none

// Takes one frame byte per cycle while full is low and reports bytes that moved
// more than change_threshold away from the value last sent for that position,
// plus a result on every frame's last byte. A new word can be pushed every
// cycle that full is low; a result passes through the classify stage register
// and the result queue before it shows on the output ports.
// The reference store is one ram with one read and one write port: each word
// reads its entry when pushed and writes it back in the next cycle, with the
// previous write forwarded. Entries beyond the highest position seen so far
// read as zero through a fill mark, so there is no clearing pass after reset.
// full rises when the four-entry result queue plus the word in flight could
// overflow, so sustained rate follows how often the consumer pops.
module frame_change_delta_encoder_top
    import fcd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [PIX_W-1:0]    pixel_byte,
    input  wire logic                frame_last,
    output logic                     empty,
    input  wire logic                pop,
    output logic [POS_W-1:0]         byte_position,
    output logic [PIX_W-1:0]         byte_value,
    output logic                     is_change,
    output logic                     frame_end,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [PIX_W-1:0]    cfg_data
);

    pix_t               threshold_reg;
    logic               accept;
    logic               stage_busy;
    logic               res_push;
    result_t            res_data;
    result_t            head;
    logic [Q_CNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    // reserve a queue slot for the word still in the classify stage
    assign full   = (Q_CNT_W'(q_count + Q_CNT_W'(stage_busy)) >= Q_CNT_W'(Q_DEPTH));
    assign accept = push && !full;

    fcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pixel_byte (pixel_byte),
        .frame_last (frame_last),
        .threshold  (threshold_reg),
        .stage_busy (stage_busy),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    fcd_result_q u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .count     (q_count)
    );

    assign byte_position = head.position;
    assign byte_value    = head.value;
    assign is_change     = head.is_change;
    assign frame_end     = head.frame_end;

    ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && q_count == Q_CNT_W'(Q_DEPTH) && !pop))
        else $error("result queue overflow");

    ap_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (is_change || frame_end))
        else $error("result with neither change nor frame end");

    ap_bare_end_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !is_change) |-> (byte_value == '0))
        else $error("bare frame end carries a value");

    ap_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> stage_busy)
        else $error("accepted word missing from classify stage");

endmodule

`default_nettype wire

// File: src/fcd_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module fcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/fcd_front.sv
// front end: position tracking, reference store lookup, change classification
`default_nettype none

module fcd_front
    import fcd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    accept,
    input  wire pix_t    pixel_byte,
    input  wire logic    frame_last,
    input  wire pix_t    threshold,
    output logic         stage_busy,
    output logic         res_push,
    output result_t      res_data
);

    addr_t             pos_reg, pos_next;
    logic [MARK_W-1:0] mark_reg, mark_next;

    logic  s1_valid_reg;
    addr_t s1_pos_reg;
    pix_t  s1_byte_reg;
    logic  s1_last_reg;
    logic  s1_init_reg;

    logic  wr_valid_reg;
    addr_t wr_addr_reg;
    pix_t  wr_data_reg;

    pix_t  ram_rdata;
    pix_t  stored;
    pix_t  wdata;
    logic  changed;

    // positions are visited as a prefix from zero, so the mark tells which
    // entries have been written at least once
    always_comb
    begin
        pos_next  = pos_reg;
        mark_next = mark_reg;
        if (accept)
        begin
            pos_next = (frame_last || pos_reg == LAST_ADDR) ? '0 : pos_reg + 1'b1;
            if ({1'b0, pos_reg} == mark_reg)
            begin
                mark_next = mark_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            mark_reg     <= '0;
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            mark_reg     <= mark_next;
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                wr_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg  <= pos_reg;
            s1_byte_reg <= pixel_byte;
            s1_last_reg <= frame_last;
            s1_init_reg <= ({1'b0, pos_reg} < mark_reg);
        end
        if (s1_valid_reg)
        begin
            wr_addr_reg <= s1_pos_reg;
            wr_data_reg <= wdata;
        end
    end

    fcd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_BYTES)
    ) u_ref_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_pos_reg),
        .wdata (wdata),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // the last write always holds the newest value for its address
    always_comb
    begin
        if (wr_valid_reg && wr_addr_reg == s1_pos_reg)
        begin
            stored = wr_data_reg;
        end
        else if (s1_init_reg)
        begin
            stored = ram_rdata;
        end
        else
        begin
            stored = '0;
        end
        changed = abs_diff(s1_byte_reg, stored) > threshold;
        wdata   = changed ? s1_byte_reg : stored;
    end

    always_comb
    begin
        res_push           = s1_valid_reg && (changed || s1_last_reg);
        res_data.position  = POS_W'(s1_pos_reg);
        res_data.value     = changed ? s1_byte_reg : '0;
        res_data.is_change = changed;
        res_data.frame_end = s1_last_reg;
    end

    assign stage_busy = s1_valid_reg;

endmodule

`default_nettype wire

// File: src/fcd_result_q.sv
// result queue between the classifier and the output side
`default_nettype none

module fcd_result_q
    import fcd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire result_t             push_data,
    input  wire logic                pop,
    output result_t                  head,
    output logic                     empty,
    output logic [Q_CNT_W-1:0]       count
);

    result_t               slots [Q_DEPTH];
    logic [Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]    count_reg, count_next;
    logic                  do_pop;

    assign empty  = (count_reg == '0);
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = slots[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire
